@@ design/rsq64_pkg.sv @@
`default_nettype none

package rsq64_pkg;

  localparam int unsigned RadW  = 64;
  localparam int unsigned RootW = 32;
  // remainder never exceeds 2*root, so root width plus two bits holds it
  localparam int unsigned RemW  = RootW + 2;
  // one result digit per step
  localparam int unsigned NumSteps = RadW / 2;

  localparam logic [RootW-1:0] RootMax = {RootW{1'b1}};

  // payload carried between digit stages
  typedef struct packed {
    logic [RadW-1:0]  rad;   // radicand bits not yet consumed, in the top bits
    logic [RootW-1:0] root;  // partial integer root
    logic [RemW-1:0]  rem;   // partial remainder
  } rsq_stage_t;

endpackage

`default_nettype wire

@@ design/rsq64_step.sv @@
`default_nettype none

// One restoring digit step with its pipeline register.
module rsq64_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire rsq64_pkg::rsq_stage_t data_i,
  output logic                     valid_o,
  output rsq64_pkg::rsq_stage_t    data_o
);
  import rsq64_pkg::*;

  logic [RemW+1:0]  rem_sh;
  logic [RemW+1:0]  trial;
  logic [RemW+1:0]  diff;
  logic             take;
  rsq_stage_t       data_d;
  rsq_stage_t       data_q;
  logic             valid_q;

  // bring down two radicand bits, compare against 4*root+1
  assign rem_sh = {data_i.rem, data_i.rad[RadW-1 -: 2]};
  assign trial  = {2'b00, data_i.root, 2'b01};
  assign diff   = rem_sh - trial;
  assign take   = (rem_sh >= trial);

  always_comb begin
    data_d.rad = {data_i.rad[RadW-3:0], 2'b00};
    if (take) begin
      data_d.rem  = diff[RemW-1:0];
      data_d.root = {data_i.root[RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh[RemW-1:0];
      data_d.root = {data_i.root[RootW-2:0], 1'b0};
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ design/rounded_integer_sqrt64.sv @@
// rounded_integer_sqrt64
// Square root of an unsigned 64-bit value, rounded to nearest, in a
// pipeline of digit stages.
//
// Input channel s_axis: one beat carries one 64-bit radicand in tdata.
// Output channel m_axis: one beat carries the 32-bit rounded root.
// A root that would round to 2^32 saturates to 4294967295.
//
// Structure: 32 digit stages, one per result bit, then the rounding
// stage that is also the output register. Throughput: one beat per
// cycle while the receiver takes beats.
//
// Each stage moves when it is empty or the next stage moves, so a
// stalled receiver fills the empty stages first, and s_axis_tready
// drops only when every stage holds a beat. Nothing is lost or
// repeated across a stall.
// Reset empties all stages; the block holds no other state.
`default_nettype none

module rounded_integer_sqrt64 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] radicand
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [31:0] root
);
  import rsq64_pkg::*;

  logic       [NumSteps:0]   valid_s;
  rsq_stage_t                data_s [NumSteps+1];
  logic       [NumSteps:0]   en_s;

  logic                      out_valid_q;
  logic       [RootW-1:0]    out_root_q;
  logic       [RootW-1:0]    root_d;
  logic                      out_en;

  // stage input from the slave side
  assign valid_s[0]       = s_axis_tvalid;
  assign data_s[0].rad    = s_axis_tdata;
  assign data_s[0].root   = '0;
  assign data_s[0].rem    = '0;
  assign s_axis_tready    = en_s[0];

  // stage enables: a stage loads when empty or when its successor loads
  assign out_en            = m_axis_tready || !out_valid_q;
  assign en_s[NumSteps]    = out_en;

  for (genvar g = 0; g < NumSteps; g++) begin : g_step
    assign en_s[g] = !valid_s[g+1] || en_s[g+1];

    rsq64_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_s[g]),
      .valid_i (valid_s[g]),
      .data_i  (data_s[g]),
      .valid_o (valid_s[g+1]),
      .data_o  (data_s[g+1])
    );
  end

  // rounding: up when remainder exceeds the integer root, saturate at max
  always_comb begin
    root_d = data_s[NumSteps].root;
    if ((data_s[NumSteps].rem > {2'b00, data_s[NumSteps].root})
        && (data_s[NumSteps].root != RootMax)) begin
      root_d = data_s[NumSteps].root + RootW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= valid_s[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && valid_s[NumSteps]) begin
      out_root_q <= root_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_root_q;

endmodule

`default_nettype wire

@@ design/rsq64_checker.sv @@
`default_nettype none

module rsq64_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [63:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // an open receiver keeps the whole pipeline moving
  a_ready_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

  // input back-pressure only when the output beat is blocked
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked output beat");

  // the pipeline starts empty after reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("output beat right after reset");

  // a blocked output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output beat changed under stall");

  // an offered input beat carries a known radicand
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid |-> !$isunknown(s_axis_tdata))
    else $error("input beat with unknown radicand bits");

endmodule

bind rounded_integer_sqrt64 rsq64_checker u_rsq64_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/sv/rounded_integer_sqrt64_tb.sv @@
module rounded_integer_sqrt64_tb;
  import rsq64_pkg::*;

  localparam int unsigned StallLimit  = 4000;  // cycles with no beat on either side
  localparam int unsigned DrainCycles = 48;    // pipeline depth plus margin
  localparam int unsigned PhaseItems  = 310;
  localparam int unsigned MaxPrinted  = 40;

  // tracks radicands in flight and the roots they must produce
  class root_scoreboard;
    typedef struct {
      logic [RadW-1:0]  rad;
      logic [RootW-1:0] root;
    } root_entry_t;

    root_entry_t pending_roots[$];
    int unsigned n_err;

    function new();
      n_err = 0;
    endfunction

    // restoring digit-by-digit root, rounded by the final remainder
    function logic [RootW-1:0] nearest_root(logic [RadW-1:0] v);
      logic [RadW-1:0] acc;
      logic [RadW-1:0] rt;
      logic [RadW-1:0] trial;
      acc = '0;
      rt  = '0;
      for (int k = NumSteps - 1; k >= 0; k--) begin
        acc   = (acc << 2) | ((v >> (2 * k)) & 64'd3);
        trial = (rt << 2) | 64'd1;
        if (acc >= trial) begin
          acc = acc - trial;
          rt  = (rt << 1) | 64'd1;
        end else begin
          rt  = rt << 1;
        end
      end
      // v >= (s + 1/2)^2 exactly when v - s^2 > s
      if (acc > rt) rt = rt + 64'd1;
      if (rt > {32'd0, RootMax}) rt = {32'd0, RootMax};
      return rt[RootW-1:0];
    endfunction

    task report_mismatch(string msg);
      if (n_err < MaxPrinted) $display("mismatch: %s", msg);
      n_err++;
    endtask

    function void note_radicand(logic [RadW-1:0] v);
      root_entry_t e;
      e.rad  = v;
      e.root = nearest_root(v);
      pending_roots.push_back(e);
    endfunction

    task check_root(logic [RootW-1:0] got);
      root_entry_t e;
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("root beat 0x%08h with no radicand in flight", got));
      end else begin
        e = pending_roots.pop_front();
        if (got !== e.root)
          report_mismatch($sformatf("radicand 0x%016h: root 0x%08h, want 0x%08h",
                                    e.rad, got, e.root));
      end
    endtask

    function int unsigned pending();
      return pending_roots.size();
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [RadW-1:0]   s_axis_tdata  = '0;   // [63:0] radicand
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [RootW-1:0]  m_axis_tdata;         // [31:0] root

  root_scoreboard sb = new();
  int unsigned    snd_idle_pct = 27;
  int unsigned    rcv_idle_pct = 83;
  int unsigned    quiet_cycles = 0;

  int unsigned snd_pcts[3] = '{27, 83, 0};
  int unsigned rcv_pcts[3] = '{83, 27, 0};

  // extremes, saturation edge, rounding edges, bit patterns
  logic [RadW-1:0] corner_rads[20] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8,
    64'd12, 64'd13,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_0000_0000,
    64'hFFFF_FFFF_0000_0001,
    64'hFFFF_FFFE_0000_0001,
    64'hFFFF_FFFE_0000_0000,
    64'h8000_0000_0000_0000,
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0001_0000_0000
  };

  rounded_integer_sqrt64 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // result side: check beats, random backpressure, stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_root(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("FAIL rounded_integer_sqrt64");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // one radicand beat, with random idle cycles ahead of it
  task automatic send_radicand(input logic [RadW-1:0] v);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      @(posedge clk_i);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_radicand(v);
  endtask

  // hold the sender until every root in flight has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // mix of uniform values, short values and values around squares
  function automatic logic [RadW-1:0] pick_radicand();
    logic [RadW-1:0] full;
    logic [RadW-1:0] s;
    full = {$urandom, $urandom};
    s    = {32'd0, $urandom >> $urandom_range(31)};
    case ($urandom_range(9))
      0, 1, 2: return full;
      3:       return full >> $urandom_range(63);
      4:       return s * s;
      5:       return s * s - 64'd1;
      6:       return s * s + s;           // largest value that still rounds down
      7:       return s * s + s + 64'd1;   // smallest value that rounds up
      8:       return {32'hFFFF_FFFF, $urandom};
      default: return 64'($urandom_range(4096));
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_rads[i]) send_radicand(corner_rads[i]);

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = snd_pcts[ph];
      rcv_idle_pct = rcv_pcts[ph];
      for (int n = 0; n < PhaseItems; n++) send_radicand(pick_radicand());
      drain_results();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("PASS rounded_integer_sqrt64");
    end else begin
      $display("FAIL rounded_integer_sqrt64");
    end
    $finish;
  end

endmodule
